@@ hw/rtl/kwc_pkg.sv @@
package kwc_pkg;

  // sample and coefficient formats
  localparam int unsigned PixW          = 8;
  localparam int unsigned CoeffW        = 16;
  localparam int unsigned CoeffFracBits = 8;
  localparam int unsigned RowTaps       = 3;
  localparam int unsigned Taps          = RowTaps * RowTaps;
  localparam int unsigned RowW          = RowTaps * CoeffW;

  // datapath widths: product, product sum, coefficient sum, magnitudes
  localparam int unsigned ProdW   = CoeffW + PixW;
  localparam int unsigned SumW    = ProdW + 4;
  localparam int unsigned WeightW = CoeffW + 4;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned DenW    = WeightW - 1;
  localparam int unsigned QuoW    = PixW;

  localparam int unsigned PixMax    = 255;
  localparam int unsigned DivSteps  = QuoW;
  // products, sums, divide setup, then one stage per quotient bit
  localparam int unsigned PipeDepth = 3 + DivSteps;
  // pipeline plus the two output holding registers
  localparam int unsigned MaxInFlight = PipeDepth + 2;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowTop = 2'd0,
    RegRowMid = 2'd1,
    RegRowBot = 2'd2
  } reg_idx_e;

  localparam logic [RowW-1:0] RowTopRst = 48'h0000_0000_0000;
  localparam logic [RowW-1:0] RowMidRst = 48'h0000_0100_0000;
  localparam logic [RowW-1:0] RowBotRst = 48'h0000_0000_0000;

  // one divider stage's payload
  typedef struct packed {
    logic            bypass;  // quo already final
    logic [QuoW-1:0] quo;
    logic [MagW-1:0] rem;
    logic [DenW-1:0] den;
  } div_t;

endpackage

@@ hw/rtl/kwc_if.sv @@
interface kwc_win_if;
  logic                         valid;
  logic                         ready;
  logic [kwc_pkg::PixW-1:0]     pix_r0c0;
  logic [kwc_pkg::PixW-1:0]     pix_r0c1;
  logic [kwc_pkg::PixW-1:0]     pix_r0c2;
  logic [kwc_pkg::PixW-1:0]     pix_r1c0;
  logic [kwc_pkg::PixW-1:0]     pix_r1c1;
  logic [kwc_pkg::PixW-1:0]     pix_r1c2;
  logic [kwc_pkg::PixW-1:0]     pix_r2c0;
  logic [kwc_pkg::PixW-1:0]     pix_r2c1;
  logic [kwc_pkg::PixW-1:0]     pix_r2c2;

  modport source (
    output valid, pix_r0c0, pix_r0c1, pix_r0c2, pix_r1c0, pix_r1c1, pix_r1c2,
           pix_r2c0, pix_r2c1, pix_r2c2,
    input  ready
  );
  modport sink (
    input  valid, pix_r0c0, pix_r0c1, pix_r0c2, pix_r1c0, pix_r1c1, pix_r1c2,
           pix_r2c0, pix_r2c1, pix_r2c2,
    output ready
  );
endinterface

interface kwc_res_if;
  logic                     valid;
  logic                     ready;
  logic [kwc_pkg::QuoW-1:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink (input valid, out_value, output ready);
endinterface

interface kwc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kwc_pkg::CfgIdxW-1:0] index;
  logic [kwc_pkg::RowW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/kwc_div_step.sv @@
module kwc_div_step #(
  parameter int unsigned QuoBit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  kwc_pkg::div_t div_i,
  output logic          valid_o,
  output kwc_pkg::div_t div_o
);

  logic [kwc_pkg::MagW-1:0] den_shift;
  logic                     take;
  kwc_pkg::div_t            div_d;
  kwc_pkg::div_t            div_q;
  logic                     valid_q;

  // one restoring step for quotient bit QuoBit
  always_comb begin
    den_shift = kwc_pkg::MagW'(div_i.den) << QuoBit;
    take      = !div_i.bypass && (div_i.rem >= den_shift);
    div_d     = div_i;
    if (take) begin
      div_d.rem         = div_i.rem - den_shift;
      div_d.quo[QuoBit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

@@ hw/rtl/kernel3x3_weighted_convolve_top.sv @@
// channel  dir  modport  payload
// win_i    in   sink     pix_r0c0 .. pix_r2c2, 8 bit samples of one 3x3 window
// res_o    out  source   out_value, 8 bit clamped normalized sum
// cfg_i    in   sink     index 2 bit, data 48 bit (three Q8.8 coefficients of a row)
//
// one window per clock when the output is taken every cycle
// depth: 11 pipeline stages plus the output register
// stages: products, sums, divide setup, then one restoring step per quotient bit
// rst_ni is asynchronous; clears valid bits and loads the identity mask
// a stall freezes the whole pipeline; a two-entry output buffer keeps win_i.ready registered
// cfg_i is always ready; the user must write rows only while no request is in flight (not enforced)
module kernel3x3_weighted_convolve_top #(
  // fraction bits of a coefficient, used to rescale a zero-weight sum
  parameter int unsigned CoeffFracBits = kwc_pkg::CoeffFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kwc_win_if.sink           win_i,
  kwc_res_if.source         res_o,
  kwc_cfg_if.sink           cfg_i
);

  localparam int unsigned PixW     = kwc_pkg::PixW;
  localparam int unsigned CoeffW   = kwc_pkg::CoeffW;
  localparam int unsigned Taps     = kwc_pkg::Taps;
  localparam int unsigned RowTaps  = kwc_pkg::RowTaps;
  localparam int unsigned ProdW    = kwc_pkg::ProdW;
  localparam int unsigned SumW     = kwc_pkg::SumW;
  localparam int unsigned WeightW  = kwc_pkg::WeightW;
  localparam int unsigned MagW     = kwc_pkg::MagW;
  localparam int unsigned DenW     = kwc_pkg::DenW;
  localparam int unsigned QuoW     = kwc_pkg::QuoW;
  localparam int unsigned DivSteps = kwc_pkg::DivSteps;

  // ---------------------------------------------------------------------------
  // coefficient rows
  // ---------------------------------------------------------------------------
  logic [kwc_pkg::RowW-1:0] row_q [RowTaps];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= kwc_pkg::RowTopRst;
      row_q[1] <= kwc_pkg::RowMidRst;
      row_q[2] <= kwc_pkg::RowBotRst;
    end else if (cfg_i.valid) begin
      case (kwc_pkg::reg_idx_e'(cfg_i.index))
        kwc_pkg::RegRowTop: row_q[0] <= cfg_i.data;
        kwc_pkg::RegRowMid: row_q[1] <= cfg_i.data;
        kwc_pkg::RegRowBot: row_q[2] <= cfg_i.data;
        default: ;  // index beyond the rows is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline enable: the whole pipe moves when the output spare slot is free
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic spare_valid_q;

  assign pipe_en     = !spare_valid_q;
  assign win_i.ready = pipe_en;

  logic win_acc;
  assign win_acc = win_i.valid && pipe_en;

  // ---------------------------------------------------------------------------
  // stage 1: nine products and the coefficient sum
  // ---------------------------------------------------------------------------
  logic [PixW-1:0]           pix       [Taps];
  logic [CoeffW-1:0]         coeff     [Taps];
  logic signed [ProdW-1:0]   prod_d    [Taps];
  logic signed [WeightW-1:0] weight_d;

  assign pix[0] = win_i.pix_r0c0;
  assign pix[1] = win_i.pix_r0c1;
  assign pix[2] = win_i.pix_r0c2;
  assign pix[3] = win_i.pix_r1c0;
  assign pix[4] = win_i.pix_r1c1;
  assign pix[5] = win_i.pix_r1c2;
  assign pix[6] = win_i.pix_r2c0;
  assign pix[7] = win_i.pix_r2c1;
  assign pix[8] = win_i.pix_r2c2;

  always_comb begin
    weight_d = '0;
    for (int t = 0; t < Taps; t++) begin
      // column 0 sits in the low bits of each row
      coeff[t]  = row_q[t / RowTaps][(t % RowTaps) * CoeffW +: CoeffW];
      // signed coefficient times zero-extended sample; the product fits ProdW
      prod_d[t] = $signed({{(ProdW - CoeffW){coeff[t][CoeffW-1]}}, coeff[t]})
                * $signed({{(ProdW - PixW){1'b0}}, pix[t]});
      weight_d  = weight_d + $signed({{(WeightW - CoeffW){coeff[t][CoeffW-1]}}, coeff[t]});
    end
  end

  logic                      s1_valid_q;
  logic signed [ProdW-1:0]   s1_prod_q [Taps];
  logic signed [WeightW-1:0] s1_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= win_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_prod_q   <= prod_d;
      s1_weight_q <= weight_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: product sum
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] sum_d;

  always_comb begin
    sum_d = '0;
    for (int t = 0; t < Taps; t++) begin
      sum_d = sum_d + $signed({{(SumW - ProdW){s1_prod_q[t][ProdW-1]}}, s1_prod_q[t]});
    end
  end

  logic                      s2_valid_q;
  logic signed [SumW-1:0]    s2_sum_q;
  logic signed [WeightW-1:0] s2_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_sum_q    <= sum_d;
      s2_weight_q <= s1_weight_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: signs, magnitudes and every case that needs no division
  // ---------------------------------------------------------------------------
  logic                sum_neg;
  logic                weight_neg;
  logic                sum_zero;
  logic                weight_zero;
  logic [SumW-1:0]     sum_abs;
  logic [WeightW-1:0]  weight_abs;
  logic [MagW-1:0]     sum_mag;
  logic [DenW-1:0]     weight_mag;
  logic [MagW-1:0]     scaled;
  logic [MagW-1:0]     quo_limit;
  kwc_pkg::div_t       prep_d;

  always_comb begin
    sum_neg     = s2_sum_q[SumW-1];
    weight_neg  = s2_weight_q[WeightW-1];
    sum_zero    = (s2_sum_q == '0);
    weight_zero = (s2_weight_q == '0);
    sum_abs     = sum_neg ? SumW'(-s2_sum_q) : SumW'(s2_sum_q);
    weight_abs  = weight_neg ? WeightW'(-s2_weight_q) : WeightW'(s2_weight_q);
    sum_mag     = sum_abs[MagW-1:0];
    weight_mag  = weight_abs[DenW-1:0];
    scaled      = sum_mag >> CoeffFracBits;
    // quotient reaches 256 or more exactly when |sum| >= 256 * |weight|
    quo_limit   = MagW'(weight_mag) << QuoW;

    prep_d        = '0;
    prep_d.rem    = sum_mag;
    prep_d.den    = weight_mag;
    prep_d.bypass = 1'b1;
    if (weight_zero) begin
      // zero weight: drop the fraction bits and clamp the result to 0..255
      if (sum_neg || sum_zero) begin
        prep_d.quo = '0;
      end else if (scaled > MagW'(kwc_pkg::PixMax)) begin
        prep_d.quo = QuoW'(kwc_pkg::PixMax);
      end else begin
        prep_d.quo = scaled[QuoW-1:0];
      end
    end else if (sum_zero || (sum_neg != weight_neg)) begin
      // negative or zero quotient clamps to zero
      prep_d.quo = '0;
    end else if (sum_mag >= quo_limit) begin
      prep_d.quo = QuoW'(kwc_pkg::PixMax);
    end else begin
      prep_d.bypass = 1'b0;
    end
  end

  logic          div_valid [DivSteps+1];
  kwc_pkg::div_t div_data  [DivSteps+1];
  logic          s3_valid_q;
  kwc_pkg::div_t s3_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_div_q <= prep_d;
    end
  end

  assign div_valid[0] = s3_valid_q;
  assign div_data[0]  = s3_div_q;

  // ---------------------------------------------------------------------------
  // stages 4..11: restoring divider, most significant quotient bit first
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    kwc_div_step #(
      .QuoBit (DivSteps - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (div_valid[k]),
      .div_i   (div_data[k]),
      .valid_o (div_valid[k+1]),
      .div_o   (div_data[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // output register with a spare slot
  // ---------------------------------------------------------------------------
  logic            push;
  logic            pop;
  logic [QuoW-1:0] push_value;
  logic            out_valid_q;
  logic [QuoW-1:0] out_value_q;
  logic [QuoW-1:0] spare_value_q;

  assign push       = pipe_en && div_valid[DivSteps];
  assign push_value = div_data[DivSteps].quo;
  assign pop        = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      // spare drains first; push cannot happen while the spare is full
      out_valid_q   <= spare_valid_q || push;
      spare_valid_q <= 1'b0;
    end else if (push) begin
      spare_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_value_q <= spare_valid_q ? spare_value_q : push_value;
    end
    if (out_valid_q && !pop && push) begin
      spare_value_q <= push_value;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_value = out_value_q;

endmodule

@@ hw/rtl/kwc_checker.sv @@
module kwc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [kwc_pkg::QuoW-1:0] out_value_i
);

  localparam int unsigned CntW = $clog2(kwc_pkg::MaxInFlight + 1) + 1;

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result changed while stalled");

  // no result without an outstanding request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without request");

  // input backs up only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // in-flight count bounded by pipeline plus output slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(kwc_pkg::MaxInFlight))
    else $error("too many requests in flight");

endmodule

bind kernel3x3_weighted_convolve_top kwc_checker u_kwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (win_i.valid),
  .in_ready_i  (win_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_value_i (res_o.out_value)
);
